// ===== rtl/pms_pkg.sv =====
// Shared types, sizes and codes for the partitioned multi-stack block.
// Used by every module under rtl/; depends on nothing else.
`timescale 1ns / 1ps

package pms_pkg;

    // Block sizing
    localparam int NUM_STACKS  = 4;
    localparam int STACK_DEPTH = 8;
    localparam int ID_WIDTH    = 16;

    // Fixed field widths of the stream beats
    localparam int CMD_W  = 2;
    localparam int SIDF_W = 3;
    localparam int ITEM_W = 16;
    localparam int STAT_W = 2;

    // Input tdata: cmd, stack_id, item_id from bit 0 up, padded to bytes
    localparam int IN_BITS     = CMD_W + SIDF_W + ITEM_W;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int CMD_LSB     = 0;
    localparam int SIDF_LSB    = CMD_W;
    localparam int ITEM_LSB    = CMD_W + SIDF_W;

    // Output tdata: status, item_out from bit 0 up, padded to bytes
    localparam int OUT_BITS    = STAT_W + ITEM_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

    // Stored identifier width: bits above the item field never survive
    localparam int STORE_W = (ID_WIDTH < ITEM_W) ? ID_WIDTH : ITEM_W;

    // Internal index widths
    localparam int SID_W     = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W     = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int MEM_DEPTH = NUM_STACKS * STACK_DEPTH;
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_DISP = 2'd2,
        CMD_RSVD = 2'd3
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_NOSTACK = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_POP     = 2'd1,
        OP_DISP    = 2'd2,
        OP_NOSTACK = 2'd3
    } op_kind_t;

    // Decoded command handed from front to back
    typedef struct packed {
        op_kind_t           kind;
        logic [SID_W-1:0]   sid;
        logic [STORE_W-1:0] item;
    } pms_op_t;

    typedef enum logic {
        BK_IDLE,
        BK_READ
    } back_state_t;

    // Word address of entry idx in the region of stack sid
    function automatic logic [ADDR_W-1:0] entry_addr(input logic [SID_W-1:0] sid,
                                                    input logic [IDX_W-1:0] idx);
        entry_addr = ADDR_W'(int'(sid) * STACK_DEPTH + int'(idx));
    endfunction

endpackage

// ===== rtl/pms_front.sv =====
// Front end: accepts input beats, drops the reserved command code and
// range-checks the stack id. Depends on pms_pkg.
`timescale 1ns / 1ps

module pms_front (
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [pms_pkg::CMD_W-1:0]    cmd,
    input  logic [pms_pkg::SIDF_W-1:0]   stack_id,
    input  logic [pms_pkg::ITEM_W-1:0]   item_id,
    input  logic                         q_full,
    output logic                         q_push,
    output pms_pkg::pms_op_t             q_op
);
    import pms_pkg::*;

    logic accept;
    logic in_range;

    // Take a beat whenever the queue has a free slot
    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign in_range = {29'd0, stack_id} < 32'(NUM_STACKS);

    // Classify the command
    always_comb
    begin
        q_push      = 1'b0;
        q_op.kind   = OP_NOSTACK;
        q_op.sid    = '0;
        q_op.item   = item_id[STORE_W-1:0];
        case (cmd_t'(cmd))
            CMD_PUSH: q_op.kind = OP_PUSH;
            CMD_POP:  q_op.kind = OP_POP;
            CMD_DISP: q_op.kind = OP_DISP;
            default:  q_op.kind = OP_NOSTACK;
        endcase
        if (!in_range)
        begin
            q_op.kind = OP_NOSTACK;
        end
        else
        begin
            q_op.sid = SID_W'(stack_id);
        end
        // reserved code: consumed, never queued
        q_push = accept && (cmd_t'(cmd) != CMD_RSVD);
    end

endmodule

// ===== rtl/pms_queue.sv =====
// Short FIFO of decoded commands between front and back.
// Depends on pms_pkg.
`timescale 1ns / 1ps

module pms_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pms_pkg::pms_op_t  op_in,
    output logic              full,
    input  logic              pop,
    output logic              valid,
    output pms_pkg::pms_op_t  op_out
);
    import pms_pkg::*;

    pms_op_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign full   = (cnt_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid  = (cnt_reg != '0);
    assign op_out = slot_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Slot storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= op_in;
        end
    end

endmodule

// ===== rtl/pms_back.sv =====
// Back end: per-stack fill counts, the shared entry memory, the display
// sequencer and the output register. Depends on pms_pkg.
`timescale 1ns / 1ps

module pms_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  pms_pkg::pms_op_t            q_op,
    output logic                        q_pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output pms_pkg::status_t            out_status,
    output logic [pms_pkg::ITEM_W-1:0]  out_item,
    output logic                        out_last
);
    import pms_pkg::*;

    back_state_t state_reg, state_next;

    logic [CNT_W-1:0]   fill_reg [NUM_STACKS];
    logic [CNT_W-1:0]   fill_next [NUM_STACKS];

    logic [SID_W-1:0]   sid_reg, sid_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   end_reg, end_next;

    logic               out_valid_reg, out_valid_next;
    status_t            out_status_reg, out_status_next;
    logic [ITEM_W-1:0]  out_item_reg, out_item_next;
    logic               out_last_reg, out_last_next;
    logic               out_load;

    logic [STORE_W-1:0] mem [MEM_DEPTH];
    logic [STORE_W-1:0] rd_data_reg;
    logic               wr_en, rd_en;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;

    logic               out_free;
    logic [CNT_W-1:0]   cnt;
    logic               is_full, is_empty;

    assign out_free = !out_valid_reg || m_tready;
    assign cnt      = fill_reg[q_op.sid];
    assign is_full  = (cnt == CNT_W'(STACK_DEPTH));
    assign is_empty = (cnt == '0);

    assign m_tvalid   = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_item   = out_item_reg;
    assign out_last   = out_last_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && out_free && !is_empty &&
                    (q_op.kind == OP_POP || q_op.kind == OP_DISP))
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ:
            begin
                if (out_free && idx_reg == end_reg)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        q_pop           = 1'b0;
        wr_en           = 1'b0;
        rd_en           = 1'b0;
        wr_addr         = entry_addr(q_op.sid, IDX_W'(cnt));
        rd_addr         = entry_addr(sid_reg, idx_reg);
        fill_next       = fill_reg;
        sid_next        = sid_reg;
        idx_next        = idx_reg;
        end_next        = end_reg;
        out_load        = 1'b0;
        out_status_next = out_status_reg;
        out_item_next   = out_item_reg;
        out_last_next   = out_last_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop           = 1'b1;
                    out_status_next = ST_OK;
                    out_item_next   = '0;
                    out_last_next   = 1'b1;
                    case (q_op.kind)
                        OP_PUSH:
                        begin
                            out_load = 1'b1;
                            if (is_full)
                            begin
                                out_status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en                = 1'b1;
                                fill_next[q_op.sid]  = cnt + 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (is_empty)
                            begin
                                out_load        = 1'b1;
                                out_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                // read the top entry, result follows next cycle
                                rd_en               = 1'b1;
                                rd_addr             = entry_addr(q_op.sid, IDX_W'(cnt - 1'b1));
                                fill_next[q_op.sid] = cnt - 1'b1;
                                sid_next            = q_op.sid;
                                idx_next            = IDX_W'(cnt - 1'b1);
                                end_next            = IDX_W'(cnt - 1'b1);
                            end
                        end
                        OP_DISP:
                        begin
                            if (is_empty)
                            begin
                                out_load        = 1'b1;
                                out_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                // walk from the bottom entry up
                                rd_en    = 1'b1;
                                rd_addr  = entry_addr(q_op.sid, '0);
                                sid_next = q_op.sid;
                                idx_next = '0;
                                end_next = IDX_W'(cnt - 1'b1);
                            end
                        end
                        default:
                        begin
                            out_load        = 1'b1;
                            out_status_next = ST_NOSTACK;
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                if (out_free)
                begin
                    out_load        = 1'b1;
                    out_status_next = ST_OK;
                    out_item_next   = ITEM_W'(rd_data_reg);
                    out_last_next   = (idx_reg == end_reg);
                    if (idx_reg != end_reg)
                    begin
                        idx_next = idx_reg + 1'b1;
                        rd_en    = 1'b1;
                        rd_addr  = entry_addr(sid_reg, idx_reg + 1'b1);
                    end
                end
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
        out_valid_next = out_load || (out_valid_reg && !m_tready);
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                fill_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            fill_reg      <= fill_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        sid_reg <= sid_next;
        idx_reg <= idx_next;
        end_reg <= end_next;
        if (out_load)
        begin
            out_status_reg <= out_status_next;
            out_item_reg   <= out_item_next;
            out_last_reg   <= out_last_next;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= q_op.item;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/partitioned_multi_stack.sv =====
// Top level of the partitioned multi-stack: front end, command queue and
// back end. Depends on pms_pkg, pms_front, pms_queue and pms_back.
`timescale 1ns / 1ps

// Several stacks share one entry memory, each stack owning a fixed region.
// Every input beat is a push, pop or display for one stack id and yields
// one result beat (display: one per stored entry, bottom first, tlast on
// the top one); command code three is consumed without a result. Inputs go
// through a two-entry queue, so up to two commands are taken while the back
// end is busy or the output is stalled. In the back end a push, a rejected
// command, a full or an empty report is answered straight from the idle
// state; a pop or a display passes through the read state, as the entry
// memory's read data is registered and is read once per result.

module partitioned_multi_stack (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [1:0] cmd, [4:2] stack_id, [20:5] item_id, [23:21] zero
    input  logic [pms_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] status, [17:2] item_out, [23:18] zero
    output logic [pms_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                            m_tlast
);
    import pms_pkg::*;

    logic              q_full, q_push, q_valid, q_pop;
    pms_op_t           front_op, back_op;
    status_t           out_status;
    logic [ITEM_W-1:0] out_item;

    pms_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (s_tdata[CMD_LSB +: CMD_W]),
        .stack_id (s_tdata[SIDF_LSB +: SIDF_W]),
        .item_id  (s_tdata[ITEM_LSB +: ITEM_W]),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (front_op)
    );

    pms_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .op_in  (front_op),
        .full   (q_full),
        .pop    (q_pop),
        .valid  (q_valid),
        .op_out (back_op)
    );

    pms_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_op       (back_op),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_status (out_status),
        .out_item   (out_item),
        .out_last   (m_tlast)
    );

    // Pack the result beat
    assign m_tdata = {{OUT_PAD_W{1'b0}}, out_item, out_status};

endmodule

// ===== rtl/pms_checker.sv =====
// Port-level checker for partitioned_multi_stack, attached by bind.
// Depends on pms_pkg and the top level's port list.
`timescale 1ns / 1ps

module pms_port_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pms_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                            m_tlast
);
    import pms_pkg::*;

    // A stalled result beat stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // Every error report is a single beat that closes its command
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[STAT_W-1:0] != ST_OK) |-> m_tlast)
        else $error("error report without tlast");

    // Error reports carry no identifier
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[STAT_W-1:0] != ST_OK) |-> (m_tdata[STAT_W +: ITEM_W] == '0))
        else $error("error report with nonzero item");

endmodule

bind partitioned_multi_stack pms_port_checker u_pms_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== test/pms_checker.sv =====
// Scoreboard for the partitioned multi-stack: watches both stream channels,
// tracks the stacks and compares every result beat. Depends on pms_pkg.
`timescale 1ns / 1ps

module pms_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // [1:0] cmd, [4:2] stack_id, [20:5] item_id, [23:21] zero
    input  logic [pms_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] status, [17:2] item_out, [23:18] zero
    input  logic [pms_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            m_tlast,
    output int                              fail_count,
    output int                              pending
);
    import pms_pkg::*;

    typedef struct packed {
        status_t           status;
        logic [ITEM_W-1:0] item;
        logic              last;
    } stack_reply_t;

    // Shadow copy of the stacks
    logic [STORE_W-1:0] shadow_mem [NUM_STACKS][STACK_DEPTH];
    int                 fill_level [NUM_STACKS];
    stack_reply_t       reply_q [$];

    cmd_t               op;
    logic [SIDF_W-1:0]  sid;
    logic [ITEM_W-1:0]  item;
    stack_reply_t       want;
    status_t            got_status;
    logic [ITEM_W-1:0]  got_item;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reply_q.delete();
            for (int i = 0; i < NUM_STACKS; i++)
                fill_level[i] = 0;
            fail_count = 0;
            pending    = 0;
        end
        else
        begin
            // Result beat: compare against the oldest expected reply
            if (m_tvalid && m_tready)
            begin
                got_status = status_t'(m_tdata[0 +: STAT_W]);
                got_item   = m_tdata[STAT_W +: ITEM_W];
                if (reply_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result beat, expected none, got %0d %h %0b",
                             $time, got_status, got_item, m_tlast);
                end
                else
                begin
                    want = reply_q.pop_front();
                    if (got_status !== want.status)
                    begin
                        fail_count++;
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, got_status);
                    end
                    if (got_item !== want.item)
                    begin
                        fail_count++;
                        $display("%0t: item_out mismatch, expected %h, got %h",
                                 $time, want.item, got_item);
                    end
                    if (m_tlast !== want.last)
                    begin
                        fail_count++;
                        $display("%0t: tlast mismatch, expected %0b, got %0b",
                                 $time, want.last, m_tlast);
                    end
                end
            end

            // Command beat: update the shadow stacks, queue the replies
            if (s_tvalid && s_tready)
            begin
                op   = cmd_t'(s_tdata[CMD_LSB +: CMD_W]);
                sid  = s_tdata[SIDF_LSB +: SIDF_W];
                item = s_tdata[ITEM_LSB +: ITEM_W];
                if (op == CMD_RSVD)
                    ; // reserved code is dropped silently
                else if (sid >= NUM_STACKS)
                    reply_q.push_back('{ST_NOSTACK, '0, 1'b1});
                else if (op == CMD_PUSH)
                begin
                    if (fill_level[sid] >= STACK_DEPTH)
                        reply_q.push_back('{ST_FULL, '0, 1'b1});
                    else
                    begin
                        shadow_mem[sid][fill_level[sid]] = item[STORE_W-1:0];
                        fill_level[sid]++;
                        reply_q.push_back('{ST_OK, '0, 1'b1});
                    end
                end
                else if (fill_level[sid] == 0)
                    reply_q.push_back('{ST_EMPTY, '0, 1'b1});
                else if (op == CMD_POP)
                begin
                    fill_level[sid]--;
                    reply_q.push_back('{ST_OK, ITEM_W'(shadow_mem[sid][fill_level[sid]]), 1'b1});
                end
                else
                begin
                    // display: bottom entry first, tlast on the top one
                    for (int k = 0; k < fill_level[sid]; k++)
                        reply_q.push_back('{ST_OK, ITEM_W'(shadow_mem[sid][k]),
                                            (k == fill_level[sid] - 1)});
                end
            end
            pending = reply_q.size();
        end
    end

endmodule

// ===== test/tb_partitioned_multi_stack.sv =====
// Testbench top: clock, reset, command stimulus, output back-pressure and
// verdict. Depends on pms_pkg, pms_checker and partitioned_multi_stack.
`timescale 1ns / 1ps

module tb_partitioned_multi_stack;
    import pms_pkg::*;

    // Longest legal stretch without a beat is the long output hold below;
    // the watchdog allows many times that.
    localparam int LONG_HOLD   = 300;
    localparam int STALL_LIMIT = 3000;
    localparam int RAND_ITEMS  = 390;
    localparam int CALM_FROM   = 330;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    int fail_count;
    int pending;
    int idle_cycles;
    bit calm;
    bit hold_req;

    partitioned_multi_stack dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    pms_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 100 MHz clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // Output side: random stall bursts, one long hold on request
    initial
    begin
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_req && !held)
            begin
                m_tready <= 1'b0;
                for (int c = 0; c < LONG_HOLD; c++)
                    @(negedge clk);
                held      = 1'b1;
                m_tready <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // One command beat, entered and left at a falling edge
    task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [SIDF_W-1:0] sid,
                            input logic [ITEM_W-1:0] item);
        logic [IN_TDATA_W-1:0] beat;
        beat = '0;
        beat[CMD_LSB +: CMD_W]   = c;
        beat[SIDF_LSB +: SIDF_W] = sid;
        beat[ITEM_LSB +: ITEM_W] = item;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Stop offering until every expected result is out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    initial
    begin
        int r;
        int push_w;
        logic [CMD_W-1:0]  c;
        logic [SIDF_W-1:0] sid;

        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        calm        = 1'b0;
        hold_req    = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: id extremes, fill to full, overflow, display, pops, empties
        send_cmd(CMD_PUSH, 3'd0, 16'h0000);
        send_cmd(CMD_PUSH, 3'd0, 16'hFFFF);
        for (int i = 0; i < STACK_DEPTH; i++)
            send_cmd(CMD_PUSH, 3'd1, (i % 2) ? 16'hAAAA : 16'h5555 + ITEM_W'(i));
        send_cmd(CMD_PUSH, 3'd1, 16'h1234);
        send_cmd(CMD_DISP, 3'd1, 16'hFFFF);
        send_cmd(CMD_POP,  3'd0, 16'hFFFF);
        send_cmd(CMD_POP,  3'd0, 16'h0000);
        send_cmd(CMD_POP,  3'd0, 16'h0000);
        send_cmd(CMD_DISP, 3'd2, 16'h0000);
        send_cmd(CMD_PUSH, 3'd4, 16'hBEEF);
        send_cmd(CMD_POP,  3'd7, 16'hFFFF);
        send_cmd(CMD_DISP, 3'd5, 16'h0000);
        send_cmd(CMD_RSVD, 3'd3, 16'hFFFF);
        send_cmd(CMD_PUSH, 3'd3, 16'h8001);
        send_cmd(CMD_DISP, 3'd3, 16'h0000);

        // Random: alternating push-heavy and pop-heavy phases
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n == 100)
            begin
                drain_results();
                hold_req = 1'b1;
            end
            if (n == 200)
                drain_results();
            calm   = (n >= CALM_FROM);
            push_w = ((n / 60) % 2) ? 20 : 70;
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                c   = CMD_RSVD;
                sid = SIDF_W'($urandom_range(0, 7));
            end
            else if (r < 9)
            begin
                c   = CMD_W'($urandom_range(0, 2));
                sid = SIDF_W'($urandom_range(NUM_STACKS, 7));
            end
            else
            begin
                // favor two stacks so they reach full and empty often
                sid = $urandom_range(0, 1) ? SIDF_W'($urandom_range(0, 1))
                                           : SIDF_W'($urandom_range(0, NUM_STACKS - 1));
                r = $urandom_range(0, 99);
                if (r < push_w)
                    c = CMD_PUSH;
                else if (r < 85)
                    c = CMD_POP;
                else
                    c = CMD_DISP;
            end
            send_cmd(c, sid, ITEM_W'($urandom_range(0, 16'hFFFF)));
        end

        // Flush and give the back end time to show any stray beat
        drain_results();
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
